// ----- rtl/leb128_decoder_core_defines.svh -----
// Assertion macros for the LEB128 decoder checker.
// Needs signals clk and rst_n in the scope where they are used.
`ifndef LEB128_DECODER_CORE_DEFINES_SVH
`define LEB128_DECODER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define LEB_ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("leb128 check failed");

// Checked at every edge, reset included.
`define LEB_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("leb128 reset check failed");

`endif

// ----- rtl/leb_pkg.sv -----
// Shared types and constants for the LEB128 decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

  localparam int LEB_WORD_BITS  = 64;
  localparam int LEB_GROUP_BITS = 7;
  localparam int LEB_SHIFT_W    = 7;
  localparam int LEB_COUNT_W    = 8;
  localparam int LEB_MAX_BYTES  = 10;
  localparam int LEB_Q_DEPTH    = 2;
  localparam int LEB_Q_PTR_W    = (LEB_Q_DEPTH > 1) ? $clog2(LEB_Q_DEPTH) : 1;
  localparam int LEB_Q_CNT_W    = $clog2(LEB_Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_signed;
  } in_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [7:0]  byte_count;
    logic        too_long;
  } out_t;

  // Classified byte as held in the queue between front and back.
  typedef struct packed {
    logic [LEB_GROUP_BITS-1:0] payload;
    logic                      last;
    logic                      sext;   // signed tag and sign bit both set, on the terminating byte only
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/leb128_decoder_core.sv -----
// Top level of the LEB128 varint decoder (up to 64-bit values).
// Depends on leb_pkg, leb_front, leb_queue, leb_back.
//
//   channel | direction | payload         | handshake
//   in      | input     | leb_pkg::in_t   | in_valid / in_ready
//   out     | output    | leb_pkg::out_t  | out_valid / out_ready
//
// One byte per cycle while the queue is not full; a byte goes front -> 2-entry queue -> back end.
// out_valid is registered and rises at the clock edge that pops the final byte from the queue.
// The accumulate step (one 64-bit shift and OR) sets the per-byte cost.
// Reset (rst_n low, synchronous) empties the queue and clears the partial value.
// An out stall blocks only final bytes; the queue absorbs the front meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module leb128_decoder_core #(
  parameter int MAX_BYTES = leb_pkg::LEB_MAX_BYTES
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire leb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output leb_pkg::out_t      out_data
);

  leb_pkg::q_status_t q_status;
  leb_pkg::q_entry_t  push_entry;
  leb_pkg::q_entry_t  pop_entry;
  logic               push_valid;
  logic               pop_valid;
  logic               pop_ready;

  leb_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  leb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_status   (q_status),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  leb_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/leb_front.sv -----
// Front end: takes input bytes and classifies them into queue entries.
// Depends on leb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module leb_front (
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire leb_pkg::in_t       in_data,
  input  wire leb_pkg::q_status_t q_status,
  output logic                    push_valid,
  output leb_pkg::q_entry_t       push_entry
);

  assign in_ready   = !q_status.full;
  assign push_valid = in_valid;

  always_comb begin
    push_entry.payload = in_data.data_byte[6:0];
    push_entry.last    = !in_data.data_byte[7];
    // only the tag of the terminating byte counts
    push_entry.sext    = in_data.is_signed & in_data.data_byte[6] & !in_data.data_byte[7];
  end

endmodule

`default_nettype wire

// ----- rtl/leb_queue.sv -----
// Short queue of classified bytes between front and back end.
// Depends on leb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module leb_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push_valid,
  input  wire leb_pkg::q_entry_t push_entry,
  output leb_pkg::q_status_t     q_status,
  input  wire                    pop_ready,
  output logic                   pop_valid,
  output leb_pkg::q_entry_t      pop_entry
);

  localparam int PW = leb_pkg::LEB_Q_PTR_W;
  localparam int CW = leb_pkg::LEB_Q_CNT_W;

  leb_pkg::q_entry_t mem_r [leb_pkg::LEB_Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign q_status.full  = (count_r == CW'(leb_pkg::LEB_Q_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_valid      = !q_status.empty;
  assign pop_entry      = mem_r[rd_ptr_r];

  assign push = push_valid && !q_status.full;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(leb_pkg::LEB_Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(leb_pkg::LEB_Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/leb_back.sv -----
// Back end: accumulates payload groups and emits finished values
// through an output register. Depends on leb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module leb_back #(
  parameter int MAX_BYTES = leb_pkg::LEB_MAX_BYTES
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    pop_valid,
  output logic                   pop_ready,
  input  wire leb_pkg::q_entry_t pop_entry,
  output logic                   out_valid,
  input  wire                    out_ready,
  output leb_pkg::out_t          out_data
);

  localparam int SW = leb_pkg::LEB_SHIFT_W;
  localparam int NW = leb_pkg::LEB_COUNT_W;
  localparam int WB = leb_pkg::LEB_WORD_BITS;

  logic [WB-1:0] acc_r, acc_nxt;
  logic [SW-1:0] shift_r, shift_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  leb_pkg::out_t out_data_r, out_data_nxt;

  logic          in_range;
  logic [WB-1:0] acc_sum;
  logic [SW-1:0] shift_sum;
  logic [NW-1:0] cnt_sum;
  logic [WB-1:0] value;
  logic          pop;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a continuation byte never waits; a final byte needs the output slot
  assign pop_ready = !pop_entry.last || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    in_range  = !shift_r[SW-1];   // shift below 64
    acc_sum   = acc_r;
    shift_sum = shift_r;
    if (in_range) begin
      acc_sum   = acc_r | (WB'(pop_entry.payload) << shift_r[SW-2:0]);
      shift_sum = shift_r + SW'(leb_pkg::LEB_GROUP_BITS);
    end
    cnt_sum = (cnt_r == {NW{1'b1}}) ? cnt_r : cnt_r + NW'(1);

    value = acc_sum;
    if (pop_entry.sext && !shift_sum[SW-1]) begin
      value = acc_sum | ({WB{1'b1}} << shift_sum[SW-2:0]);
    end

    acc_nxt       = acc_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (pop) begin
      if (pop_entry.last) begin
        acc_nxt                 = '0;
        shift_nxt               = '0;
        cnt_nxt                 = '0;
        out_valid_nxt           = 1'b1;
        out_data_nxt.value_bits = value;
        out_data_nxt.byte_count = cnt_sum;
        out_data_nxt.too_long   = (cnt_sum > NW'(MAX_BYTES));
      end else begin
        acc_nxt   = acc_sum;
        shift_nxt = shift_sum;
        cnt_nxt   = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      shift_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      shift_r     <= shift_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/leb_chk.sv -----
// Port-level checker for leb128_decoder_core, attached by bind.
// Depends on leb_pkg and leb128_decoder_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "leb128_decoder_core_defines.svh"

module leb_chk #(
  parameter int MAX_BYTES = leb_pkg::LEB_MAX_BYTES
) (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input wire leb_pkg::out_t out_data
);

  // stalled result transaction holds
  `LEB_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // every value consumed at least one byte
  `LEB_ASSERT_RUN(a_count_nonzero, out_valid |-> out_data.byte_count != 8'd0)
  // overlong flag agrees with the byte count
  `LEB_ASSERT_RUN(a_too_long, out_valid |-> out_data.too_long == (out_data.byte_count > 8'(MAX_BYTES)))
  // reset drops any pending result
  `LEB_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid)

endmodule

bind leb128_decoder_core leb_chk #(
  .MAX_BYTES (MAX_BYTES)
) u_leb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
